// ===== src/srpt_pkg.sv =====
// Shared types and constants for the SRPT sorted queue with spill.
// No dependencies.
`default_nettype none
package srpt_pkg;
	localparam int unsigned ST_W = 48;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned OCC_W = 7;
	localparam int unsigned BLK_W = 5;

	localparam logic [1:0] MODE_SERVE = 2'd0;
	localparam logic [1:0] MODE_ARRIVE = 2'd1;
	localparam logic [1:0] MODE_REFILL = 2'd2;

	localparam logic [2:0] KIND_STATUS = 3'd0;
	localparam logic [2:0] KIND_DONE = 3'd1;
	localparam logic [2:0] KIND_SPILL = 3'd2;
	localparam logic [2:0] KIND_REFILL = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	localparam logic [1:0] REG_HIGH = 2'd0;
	localparam logic [1:0] REG_LOW = 2'd1;
	localparam logic [1:0] REG_BLOCK = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [LEN_W-1:0] elapsed;
		logic [ST_W-1:0] start_time;
		logic [LEN_W-1:0] job_length;
		logic [LEN_W-1:0] job_remaining;
		logic store_has_entries;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [ST_W-1:0] out_start_time;
		logic [LEN_W-1:0] out_length;
		logic [LEN_W-1:0] out_remaining;
		logic [OCC_W-1:0] occupancy;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [ST_W-1:0] st;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] rem;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SERVE_RD, S_SERVE_CHK, S_SHIFT_DN, S_SHIFT_RD,
		S_FIND_RD, S_FIND_CHK, S_SHIFT_UP, S_SPILL_RD, S_SPILL_EMIT,
		S_EMIT
	} state_t;
endpackage
`default_nettype wire

// ===== src/srpt_store.sv =====
// Entry memory for the sorted queue: one write port, one registered read port.
// Depends on srpt_pkg.
`default_nettype none
module srpt_store #(
	parameter int unsigned AW = 6
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire srpt_pkg::entry_t wdata,
	input wire logic [AW-1:0] raddr,
	output srpt_pkg::entry_t rdata
);
	srpt_pkg::entry_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/srpt_sorted_queue_with_spill.sv =====
// Top level: SRPT sorted queue, sequencer over one entry memory and one
// shared 32-bit compare/subtract unit. Depends on srpt_pkg, srpt_store.
//
//  channel | valid     | ready     | payload
//  in      | in_valid  | in_ready  | in_data  (srpt_pkg::in_item_t)
//  out     | out_valid | out_ready | out_data (srpt_pkg::out_item_t)
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// An insert walks the whole store through the compare unit, one entry at a time.
// A head removal shifts each remaining entry down; a partial service rewrites the
// head in place. Each spilled entry is read from the tail and then emitted.
// Reset clears the count and control and loads the config registers with defaults; entries need no clearing.
// in_ready is low while a request is in work; a stalled result holds the
// sequencer in place.
`default_nettype none
module srpt_sorted_queue_with_spill #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned MAX_BLOCK = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire srpt_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output srpt_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned OW = srpt_pkg::OCC_W;
	localparam int unsigned LW = srpt_pkg::LEN_W;
	localparam int unsigned XW = (CW > OW) ? CW : OW;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);
	localparam logic [srpt_pkg::BLK_W-1:0] MAXB =
		(MAX_BLOCK > 31) ? 5'd31 : srpt_pkg::BLK_W'(MAX_BLOCK);

	srpt_pkg::state_t state_q, state_d;
	srpt_pkg::in_item_t req_q;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [srpt_pkg::BLK_W-1:0] left_q, left_d;
	logic [OW-1:0] high_q, low_q;
	logic [srpt_pkg::BLK_W-1:0] blk_q;
	logic any_q, any_d;
	logic moving_q, moving_d;
	logic [1:0] post_q, post_d;
	srpt_pkg::out_item_t res_q, res_d;
	logic ovalid_q, ovalid_d;
	srpt_pkg::entry_t hold_q, hold_d;

	logic we;
	logic [AW-1:0] waddr, raddr;
	srpt_pkg::entry_t wdata, rdata;

	logic [srpt_pkg::BLK_W-1:0] eff_blk;
	logic [LW-1:0] alu_a, alu_b, alu_diff;
	logic alu_ge;
	logic [LW-1:0] ins_rem;
	logic [XW-1:0] cnt_x, cnt_m1_x, high_x, low_x;
	logic refill_now, refill_dn, spill_now, spill_dn;

	localparam logic [1:0] POST_SPILL = 2'd0;
	localparam logic [1:0] POST_REFILL = 2'd1;
	localparam logic [1:0] POST_DONE = 2'd2;

	srpt_store #(.AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign eff_blk = (blk_q > MAXB) ? MAXB : blk_q;
	assign {alu_ge, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b} ^ {1'b1, {LW{1'b0}}};
	assign ins_rem = (req_q.mode == srpt_pkg::MODE_ARRIVE) ? req_q.job_length :
		req_q.job_remaining;
	assign cnt_x = XW'(cnt_q);
	assign cnt_m1_x = XW'(cnt_q - 1'b1);
	assign high_x = XW'(high_q);
	assign low_x = XW'(low_q);
	assign refill_now = (cnt_x <= low_x) && req_q.store_has_entries && (eff_blk != '0);
	assign refill_dn = (cnt_m1_x <= low_x) && req_q.store_has_entries && (eff_blk != '0);
	assign spill_now = (cnt_x >= high_x) && (eff_blk != '0) && (cnt_q != '0);
	assign spill_dn = (cnt_m1_x >= high_x) && (eff_blk != '0) && (cnt_m1_x != '0);
	assign in_ready = (state_q == srpt_pkg::S_IDLE);
	assign cfg_ready = (state_q == srpt_pkg::S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srpt_pkg::S_IDLE;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			high_q <= 7'd48;
			low_q <= 7'd8;
			blk_q <= 5'd8;
			any_q <= 1'b0;
			post_q <= POST_SPILL;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			ovalid_q <= ovalid_d;
			any_q <= any_d;
			post_q <= post_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					srpt_pkg::REG_HIGH: high_q <= cfg_data[OW-1:0];
					srpt_pkg::REG_LOW: low_q <= cfg_data[OW-1:0];
					srpt_pkg::REG_BLOCK: blk_q <= cfg_data[srpt_pkg::BLK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= in_data;
		end
		ptr_q <= ptr_d;
		left_q <= left_d;
		res_q <= res_d;
		hold_q <= hold_d;
		moving_q <= moving_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ptr_d = ptr_q;
		left_d = left_q;
		any_d = any_q;
		moving_d = moving_q;
		post_d = post_q;
		res_d = res_q;
		ovalid_d = ovalid_q;
		hold_d = hold_q;
		we = 1'b0;
		waddr = '0;
		wdata = hold_q;
		raddr = '0;
		alu_a = rdata.rem;
		alu_b = req_q.elapsed;
		if (ovalid_q && out_ready) begin
			ovalid_d = 1'b0;
		end
		case (state_q)
			srpt_pkg::S_IDLE: begin
				any_d = 1'b0;
				if (in_valid) begin
					state_d = srpt_pkg::S_DECODE;
				end
			end
			srpt_pkg::S_DECODE: begin
				ptr_d = '0;
				moving_d = 1'b0;
				case (req_q.mode)
					srpt_pkg::MODE_SERVE: begin
						if (cnt_q != '0) begin
							state_d = srpt_pkg::S_SERVE_RD;
						end else begin
							post_d = POST_REFILL;
							state_d = srpt_pkg::S_EMIT;
						end
					end
					srpt_pkg::MODE_ARRIVE, srpt_pkg::MODE_REFILL: begin
						hold_d = '{st: req_q.start_time, len: req_q.job_length,
							rem: ins_rem};
						if (ins_rem == '0) begin
							post_d = POST_SPILL;
							state_d = srpt_pkg::S_EMIT;
						end else if (cnt_q >= CAP) begin
							if (!ovalid_q || out_ready) begin
								res_d = '{kind: srpt_pkg::KIND_REJECT,
									out_start_time: req_q.start_time,
									out_length: req_q.job_length,
									out_remaining: ins_rem, occupancy: OW'(cnt_q),
									last: !spill_now};
								ovalid_d = 1'b1;
								any_d = 1'b1;
								post_d = POST_SPILL;
								state_d = srpt_pkg::S_EMIT;
							end
						end else if (cnt_q == '0) begin
							state_d = srpt_pkg::S_SHIFT_UP;
						end else begin
							state_d = srpt_pkg::S_FIND_RD;
						end
					end
					default: begin
						post_d = POST_SPILL;
						state_d = srpt_pkg::S_EMIT;
					end
				endcase
			end
			srpt_pkg::S_SERVE_RD: begin
				raddr = '0;
				state_d = srpt_pkg::S_SERVE_CHK;
			end
			srpt_pkg::S_SERVE_CHK: begin
				raddr = '0;
				if (!alu_ge || alu_diff == '0) begin
					if (!ovalid_q || out_ready) begin
						res_d = '{kind: srpt_pkg::KIND_DONE, out_start_time: rdata.st,
							out_length: rdata.len, out_remaining: '0,
							occupancy: OW'(cnt_q - 1'b1),
							last: !(refill_dn || spill_dn)};
						ovalid_d = 1'b1;
						any_d = 1'b1;
						cnt_d = cnt_q - 1'b1;
						ptr_d = CW'(1);
						state_d = srpt_pkg::S_SHIFT_RD;
					end
				end else begin
					we = 1'b1;
					waddr = '0;
					wdata = '{st: rdata.st, len: rdata.len, rem: alu_diff};
					post_d = POST_REFILL;
					state_d = srpt_pkg::S_EMIT;
				end
			end
			srpt_pkg::S_SHIFT_RD: begin
				raddr = ptr_q[AW-1:0];
				if (ptr_q > cnt_q) begin
					post_d = POST_REFILL;
					state_d = srpt_pkg::S_EMIT;
				end else begin
					state_d = srpt_pkg::S_SHIFT_DN;
				end
			end
			srpt_pkg::S_SHIFT_DN: begin
				we = 1'b1;
				waddr = AW'(ptr_q - 1'b1);
				wdata = rdata;
				ptr_d = ptr_q + 1'b1;
				state_d = srpt_pkg::S_SHIFT_RD;
			end
			srpt_pkg::S_FIND_RD: begin
				raddr = ptr_q[AW-1:0];
				state_d = srpt_pkg::S_FIND_CHK;
			end
			srpt_pkg::S_FIND_CHK: begin
				alu_a = hold_q.rem;
				alu_b = rdata.rem;
				if (alu_ge && !moving_q) begin
					ptr_d = ptr_q + 1'b1;
					state_d = (ptr_q + 1'b1 == cnt_q) ? srpt_pkg::S_SHIFT_UP :
						srpt_pkg::S_FIND_RD;
				end else begin
					we = 1'b1;
					waddr = ptr_q[AW-1:0];
					wdata = hold_q;
					hold_d = rdata;
					moving_d = 1'b1;
					ptr_d = ptr_q + 1'b1;
					state_d = (ptr_q + 1'b1 == cnt_q) ? srpt_pkg::S_SHIFT_UP :
						srpt_pkg::S_FIND_RD;
				end
			end
			srpt_pkg::S_SHIFT_UP: begin
				we = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = hold_q;
				cnt_d = cnt_q + 1'b1;
				post_d = POST_SPILL;
				state_d = srpt_pkg::S_EMIT;
			end
			srpt_pkg::S_SPILL_RD: begin
				raddr = AW'(cnt_q - 1'b1);
				state_d = srpt_pkg::S_SPILL_EMIT;
			end
			srpt_pkg::S_SPILL_EMIT: begin
				raddr = AW'(cnt_q - 1'b1);
				if (!ovalid_q || out_ready) begin
					res_d = '{kind: srpt_pkg::KIND_SPILL, out_start_time: rdata.st,
						out_length: rdata.len, out_remaining: rdata.rem,
						occupancy: OW'(cnt_q - 1'b1),
						last: (left_q == 5'd1 || cnt_q == CW'(1))};
					ovalid_d = 1'b1;
					any_d = 1'b1;
					cnt_d = cnt_q - 1'b1;
					left_d = left_q - 1'b1;
					if (left_q == 5'd1 || cnt_q == CW'(1)) begin
						post_d = POST_DONE;
						state_d = srpt_pkg::S_EMIT;
					end else begin
						state_d = srpt_pkg::S_SPILL_RD;
					end
				end
			end
			srpt_pkg::S_EMIT: begin
				case (post_q)
					POST_REFILL: begin
						if (refill_now) begin
							if (!ovalid_q || out_ready) begin
								res_d = '{kind: srpt_pkg::KIND_REFILL, out_start_time: '0,
									out_length: '0, out_remaining: LW'(eff_blk),
									occupancy: OW'(cnt_q), last: !spill_now};
								ovalid_d = 1'b1;
								any_d = 1'b1;
								post_d = POST_SPILL;
							end
						end else begin
							post_d = POST_SPILL;
						end
					end
					POST_SPILL: begin
						left_d = eff_blk;
						if (spill_now) begin
							state_d = srpt_pkg::S_SPILL_RD;
						end else begin
							post_d = POST_DONE;
						end
					end
					default: begin
						if (any_q) begin
							state_d = srpt_pkg::S_IDLE;
						end else if (!ovalid_q || out_ready) begin
							res_d = '{kind: srpt_pkg::KIND_STATUS, out_start_time: '0,
								out_length: '0, out_remaining: '0,
								occupancy: OW'(cnt_q), last: 1'b1};
							ovalid_d = 1'b1;
							state_d = srpt_pkg::S_IDLE;
						end
					end
				endcase
			end
			default: state_d = srpt_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== bench/srpt_sorted_queue_with_spill_tb.sv =====
// Testbench for the SRPT sorted queue with spill: a stimulus table, then random
// requests, all checked against a built-in sorted-queue predictor.
// Depends on srpt_pkg and srpt_sorted_queue_with_spill.
`default_nettype none
module srpt_sorted_queue_with_spill_tb;
	localparam int CAP = 64;
	localparam int MAXB = 16;
	localparam int LIMIT = 2000000;
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct {
		srpt_pkg::in_item_t req;
		bit has_exp;
		srpt_pkg::out_item_t exp;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	srpt_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	srpt_pkg::out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	srpt_pkg::entry_t queue_q[$];
	int unsigned hi_mark;
	int unsigned lo_mark;
	int unsigned blk_reg;
	srpt_pkg::out_item_t expected_results[$];
	int errors;
	int cycles;
	bit hold_off;
	row_t rows[$];

	srpt_sorted_queue_with_spill u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic srpt_pkg::out_item_t make_result(logic [2:0] k, logic [47:0] st,
			logic [31:0] len, logic [31:0] rem, int unsigned occ);
		srpt_pkg::out_item_t r;
		r.kind = k;
		r.out_start_time = st;
		r.out_length = len;
		r.out_remaining = rem;
		r.occupancy = occ[6:0];
		r.last = 0;
		return r;
	endfunction

	function automatic void queue_insert(logic [47:0] st, logic [31:0] len,
			logic [31:0] rem, ref srpt_pkg::out_item_t res[$]);
		int pos;
		srpt_pkg::entry_t e;
		if (rem == 0)
			return;
		if (queue_q.size() >= CAP) begin
			res.push_back(make_result(srpt_pkg::KIND_REJECT, st, len, rem, queue_q.size()));
			return;
		end
		pos = 0;
		while (pos < queue_q.size() && queue_q[pos].rem <= rem)
			pos++;
		e.st = st;
		e.len = len;
		e.rem = rem;
		queue_q.insert(pos, e);
	endfunction

	function automatic void predict_request(srpt_pkg::in_item_t r);
		srpt_pkg::out_item_t res[$];
		int unsigned blk;
		srpt_pkg::entry_t e;
		blk = blk_reg > MAXB ? MAXB : blk_reg;
		if (r.mode == srpt_pkg::MODE_SERVE) begin
			if (queue_q.size() > 0) begin
				if (r.elapsed >= queue_q[0].rem) begin
					e = queue_q.pop_front();
					res.push_back(make_result(srpt_pkg::KIND_DONE, e.st, e.len, 0,
						queue_q.size()));
				end else
					queue_q[0].rem = queue_q[0].rem - r.elapsed;
			end
			if (queue_q.size() <= lo_mark && r.store_has_entries && blk > 0)
				res.push_back(make_result(srpt_pkg::KIND_REFILL, 0, 0, blk, queue_q.size()));
		end else if (r.mode == srpt_pkg::MODE_ARRIVE)
			queue_insert(r.start_time, r.job_length, r.job_length, res);
		else if (r.mode == srpt_pkg::MODE_REFILL)
			queue_insert(r.start_time, r.job_length, r.job_remaining, res);
		if (queue_q.size() >= hi_mark)
			for (int i = 0; i < blk && queue_q.size() > 0; i++) begin
				e = queue_q.pop_back();
				res.push_back(make_result(srpt_pkg::KIND_SPILL, e.st, e.len, e.rem,
					queue_q.size()));
			end
		if (res.size() == 0)
			res.push_back(make_result(srpt_pkg::KIND_STATUS, 0, 0, 0, queue_q.size()));
		res[res.size()-1].last = 1;
		foreach (res[i])
			expected_results.push_back(res[i]);
	endfunction

	task automatic send_request(srpt_pkg::in_item_t r);
		int gap;
		gap = $urandom_range(0, 15);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) @(posedge clk);
		in_valid <= 1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		predict_request(r);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == srpt_pkg::REG_HIGH)
			hi_mark = val & 7'h7f;
		else if (idx == srpt_pkg::REG_LOW)
			lo_mark = val & 7'h7f;
		else if (idx == srpt_pkg::REG_BLOCK)
			blk_reg = val & 5'h1f;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic srpt_pkg::in_item_t rand_request(int unsigned lenmax);
		srpt_pkg::in_item_t r;
		int unsigned p;
		p = $urandom_range(0, 99);
		r.mode = p < 35 ? srpt_pkg::MODE_SERVE : (p < 75 ? srpt_pkg::MODE_ARRIVE :
			(p < 97 ? srpt_pkg::MODE_REFILL : MODE_NOP));
		r.elapsed = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, lenmax);
		r.start_time = 48'({$urandom(), $urandom()});
		r.job_length = $urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(0, lenmax);
		r.job_remaining = $urandom_range(0, 15) == 0 ? $urandom() :
			$urandom_range(0, lenmax);
		r.store_has_entries = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic void add_row(logic [1:0] m, logic [31:0] el, logic [47:0] st,
			logic [31:0] len, logic [31:0] rem, bit store, bit chk,
			srpt_pkg::out_item_t ex);
		row_t w;
		w.req.mode = m;
		w.req.elapsed = el;
		w.req.start_time = st;
		w.req.job_length = len;
		w.req.job_remaining = rem;
		w.req.store_has_entries = store;
		w.has_exp = chk;
		w.exp = ex;
		rows.push_back(w);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0)
				report("result with nothing expected");
			else begin
				srpt_pkg::out_item_t x;
				x = expected_results.pop_front();
				if (out_data.kind !== x.kind)
					report($sformatf("kind %0d exp %0d", out_data.kind, x.kind));
				if (out_data.out_start_time !== x.out_start_time)
					report($sformatf("start %h exp %h", out_data.out_start_time,
						x.out_start_time));
				if (out_data.out_length !== x.out_length)
					report($sformatf("length %h exp %h", out_data.out_length, x.out_length));
				if (out_data.out_remaining !== x.out_remaining)
					report($sformatf("remaining %h exp %h", out_data.out_remaining,
						x.out_remaining));
				if (out_data.occupancy !== x.occupancy)
					report($sformatf("occupancy %0d exp %0d", out_data.occupancy,
						x.occupancy));
				if (out_data.last !== x.last)
					report($sformatf("last %0d exp %0d", out_data.last, x.last));
			end
		end
	end

	initial begin
		int stall;
		out_ready = 0;
		forever begin
			@(posedge clk);
			if (hold_off)
				out_ready <= 0;
			else begin
				stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
				if (stall == 0)
					out_ready <= 1;
				else begin
					out_ready <= 0;
					repeat (stall) @(posedge clk);
					out_ready <= 1;
				end
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		srpt_pkg::out_item_t s;
		srpt_pkg::in_item_t r;
		int n;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = srpt_pkg::REG_HIGH;
		cfg_data = 0;
		hold_off = 0;
		errors = 0;
		hi_mark = 48;
		lo_mark = 8;
		blk_reg = 8;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		s = make_result(srpt_pkg::KIND_STATUS, 0, 0, 0, 0);
		s.last = 1;
		add_row(srpt_pkg::MODE_SERVE, 5, 0, 0, 0, 0, 1, s);
		s = make_result(srpt_pkg::KIND_REFILL, 0, 0, 8, 0);
		s.last = 1;
		add_row(srpt_pkg::MODE_SERVE, 32'hffffffff, 0, 0, 0, 1, 1, s);
		s = make_result(srpt_pkg::KIND_STATUS, 0, 0, 0, 0);
		s.last = 1;
		add_row(srpt_pkg::MODE_ARRIVE, 0, 48'hffffffffffff, 0, 7, 1, 1, s);
		add_row(srpt_pkg::MODE_REFILL, 0, 48'h123, 9, 0, 0, 1, s);
		add_row(MODE_NOP, 32'hffffffff, 48'hffffffffffff, 32'hffffffff, 32'hffffffff,
			1, 1, s);
		add_row(srpt_pkg::MODE_ARRIVE, 0, 48'hffffffffffff, 32'hffffffff, 0, 0, 0, s);
		add_row(srpt_pkg::MODE_ARRIVE, 0, 1, 10, 0, 0, 0, s);
		add_row(srpt_pkg::MODE_ARRIVE, 0, 2, 10, 0, 0, 0, s);
		add_row(srpt_pkg::MODE_REFILL, 0, 3, 50, 10, 0, 0, s);
		add_row(srpt_pkg::MODE_REFILL, 0, 0, 0, 1, 1, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 0, 0, 0, 0, 1, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 1, 0, 0, 0, 0, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 4, 0, 0, 0, 1, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 32'hffffffff, 0, 0, 0, 1, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 32'hffffffff, 0, 0, 0, 0, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 32'hffffffff, 0, 0, 0, 1, 0, s);
		add_row(srpt_pkg::MODE_SERVE, 32'hffffffff, 0, 0, 0, 1, 0, s);
		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				while (expected_results.size() > 0)
					@(posedge clk);
				send_request(rows[i].req);
				if (expected_results.size() != 1 || expected_results[0] != rows[i].exp)
					report($sformatf("table row %0d prediction", i));
			end else
				send_request(rows[i].req);
		end
		drain();

		// drive the queue to full with a spill mark out of reach, then fill past it
		write_reg(srpt_pkg::REG_HIGH, 127);
		write_reg(srpt_pkg::REG_BLOCK, 31);
		write_reg(srpt_pkg::REG_LOW, 0);
		write_reg(REG_SPARE, 5);
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 70; i++) begin
				r = rand_request(1000);
				r.mode = i % 7 == 0 ? srpt_pkg::MODE_REFILL : srpt_pkg::MODE_ARRIVE;
				r.job_length |= 1;
				r.job_remaining |= 1;
				send_request(r);
			end
		join
		drain();

		write_reg(srpt_pkg::REG_HIGH, 1);
		write_reg(srpt_pkg::REG_BLOCK, 0);
		r = rand_request(100);
		r.mode = srpt_pkg::MODE_SERVE;
		r.store_has_entries = 1;
		send_request(r);
		send_request(r);
		drain();
		write_reg(srpt_pkg::REG_BLOCK, 16);
		write_reg(srpt_pkg::REG_LOW, 64);
		for (int i = 0; i < 8; i++)
			send_request(rand_request(100));
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(srpt_pkg::REG_HIGH, 48);
					write_reg(srpt_pkg::REG_LOW, 8);
					write_reg(srpt_pkg::REG_BLOCK, 8);
				end
				1: begin
					write_reg(srpt_pkg::REG_HIGH, 12);
					write_reg(srpt_pkg::REG_LOW, 3);
					write_reg(srpt_pkg::REG_BLOCK, 1);
				end
				2: begin
					write_reg(srpt_pkg::REG_HIGH, 64);
					write_reg(srpt_pkg::REG_LOW, 20);
					write_reg(srpt_pkg::REG_BLOCK, 16);
				end
				default: begin
					write_reg(srpt_pkg::REG_HIGH, $urandom_range(1, 64));
					write_reg(srpt_pkg::REG_LOW, $urandom_range(0, 64));
					write_reg(srpt_pkg::REG_BLOCK, $urandom_range(1, 16));
				end
			endcase
			n = ph == 3 ? 10 : 15;
			for (int i = 0; i < n; i++)
				send_request(rand_request(ph == 1 ? 20 : 5000));
			drain();
		end

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
src/srpt_pkg.sv
src/srpt_store.sv
src/srpt_sorted_queue_with_spill.sv
bench/srpt_sorted_queue_with_spill_tb.sv
